// ===== sv/gkps_pkg.sv =====
package gkps_pkg;

  localparam int MatrixDim    = 256;
  localparam int BlockColumns = 16;
  localparam int WordBits     = 64;
  localparam int VecWords     = MatrixDim / WordBits;
  localparam int RowW         = (MatrixDim > 1) ? $clog2(MatrixDim) : 1;
  localparam int ColW         = (BlockColumns > 1) ? $clog2(BlockColumns) : 1;
  localparam int WordW        = (VecWords > 1) ? $clog2(VecWords) : 1;
  localparam int StepW        = 16;

  typedef logic [MatrixDim-1:0]    vec_t;
  typedef vec_t [BlockColumns-1:0] blk_vec_t;
  typedef logic [RowW-1:0]         row_t;
  typedef logic [ColW-1:0]         col_t;
  typedef logic [WordW-1:0]        word_t;
  typedef logic [BlockColumns-1:0] bits_t;

  typedef enum logic [1:0] {
    OP_LOAD_MATRIX = 2'd0,
    OP_LOAD_PROJ   = 2'd1,
    OP_LOAD_START  = 2'd2,
    OP_STEP        = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROJ,
    ST_MUL,
    ST_DRAIN
  } state_e;

  // Control from the sequencer to the projection and Krylov store.
  typedef struct packed {
    logic                x_we;
    logic                y_we;
    col_t                col;
    word_t               word;
    logic [WordBits-1:0] data;
    logic                upd_en;
    row_t                upd_row;
    bits_t               upd_bits;
    logic                flip;
    col_t                proj_col;
  } blk_ctrl_t;

endpackage

// ===== sv/gkps_matrix_mem.sv =====
module gkps_matrix_mem
  import gkps_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  row_t                waddr_i,
  input  word_t               wword_i,
  input  logic [WordBits-1:0] wdata_i,
  input  logic                re_i,
  input  row_t                raddr_i,
  output vec_t                rdata_o
);

  // One matrix row per entry, written one 64-bit lane at a time.
  logic [VecWords-1:0][WordBits-1:0] mem_q [MatrixDim];
  logic [VecWords-1:0][WordBits-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wword_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

// ===== sv/gkps_block_store.sv =====
module gkps_block_store
  import gkps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  blk_ctrl_t ctrl_i,
  output vec_t      x_col_o,
  output blk_vec_t  y_act_o
);

  vec_t x_q [BlockColumns];
  vec_t y_q [2][BlockColumns];
  logic sel_q;
  logic nsel;

  assign nsel = ~sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (ctrl_i.flip) begin
      sel_q <= nsel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.x_we) begin
      x_q[ctrl_i.col][{ctrl_i.word, 6'b0} +: WordBits] <= ctrl_i.data;
    end
  end

  // Start words land in the active half; products land in the other half.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.y_we) begin
      y_q[sel_q][ctrl_i.col][{ctrl_i.word, 6'b0} +: WordBits] <= ctrl_i.data;
    end
    if (ctrl_i.upd_en) begin
      for (int j = 0; j < BlockColumns; j++) begin
        y_q[nsel][j][ctrl_i.upd_row] <= ctrl_i.upd_bits[j];
      end
    end
  end

  assign x_col_o = x_q[ctrl_i.proj_col];

  always_comb begin
    for (int j = 0; j < BlockColumns; j++) begin
      y_act_o[j] = y_q[sel_q][j];
    end
  end

endmodule

// ===== sv/gkps_parity_unit.sv =====
module gkps_parity_unit
  import gkps_pkg::*;
(
  input  vec_t     a_i,
  input  blk_vec_t b_i,
  output bits_t    bits_o
);

  // One GF(2) inner product per Krylov column, all columns side by side.
  always_comb begin
    for (int j = 0; j < BlockColumns; j++) begin
      bits_o[j] = ^(a_i & b_i[j]);
    end
  end

endmodule

// ===== sv/gf2_krylov_projection_sequence_unit.sv =====
// Sequence: load beats are taken only while idle. A step beat enters ST_PROJ,
// which registers each projection row into the output (one per cycle while the
// output drains); ST_MUL then reads every matrix row, ST_DRAIN writes back the
// last product row as the halves swap, and input stalls until the return to idle.
// Reset clears the sequencer, output valid, buffer select and step counter;
// the matrix, projection and Krylov stores are undefined until loaded.
module gf2_krylov_projection_sequence_unit
  import gkps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          target_index_i,
  input  logic [1:0]          word_index_i,
  input  logic [63:0]         data_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [StepW-1:0]    step_index_o,
  output logic [3:0]          row_index_o,
  output logic [15:0]         row_bits_o,
  output logic                last_o
);

  state_e            state_q, state_d;
  col_t              proj_q, proj_d;
  row_t              row_q, row_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              rd_valid_q;
  row_t              rd_row_q;
  logic              rd_en;
  logic              out_load;
  logic              flip;

  logic              out_valid_q, out_valid_d;
  logic [StepW-1:0]  step_index_q;
  logic [3:0]        row_index_q;
  logic [15:0]       row_bits_q;
  logic              last_q;

  logic              accept;
  op_e               op;
  logic              col_ok, row_ok, word_ok;
  logic              out_free;
  logic              mem_we;

  vec_t              mem_rd;
  vec_t              x_col;
  blk_vec_t          y_act;
  vec_t              par_a;
  bits_t             par_bits;
  blk_ctrl_t         ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = op_e'(opcode_i);
  assign col_ok     = int'(target_index_i) < BlockColumns;
  assign row_ok     = int'(target_index_i) < MatrixDim;
  assign word_ok    = int'(word_index_i) < VecWords;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mem_we     = accept && (op == OP_LOAD_MATRIX) && row_ok && word_ok;

  gkps_matrix_mem u_matrix_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (RowW'(target_index_i)),
    .wword_i (WordW'(word_index_i)),
    .wdata_i (data_word_i),
    .re_i    (rd_en),
    .raddr_i (row_q),
    .rdata_o (mem_rd)
  );

  always_comb begin
    ctrl          = '0;
    ctrl.x_we     = accept && (op == OP_LOAD_PROJ) && col_ok && word_ok;
    ctrl.y_we     = accept && (op == OP_LOAD_START) && col_ok && word_ok;
    ctrl.col      = ColW'(target_index_i);
    ctrl.word     = WordW'(word_index_i);
    ctrl.data     = data_word_i;
    ctrl.upd_en   = rd_valid_q;
    ctrl.upd_row  = rd_row_q;
    ctrl.upd_bits = par_bits;
    ctrl.flip     = flip;
    ctrl.proj_col = proj_q;
  end

  gkps_block_store u_block_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .x_col_o (x_col),
    .y_act_o (y_act)
  );

  // The same parity lanes serve the projection rows and the matrix product.
  assign par_a = (state_q == ST_PROJ) ? x_col : mem_rd;

  gkps_parity_unit u_parity_unit (
    .a_i    (par_a),
    .b_i    (y_act),
    .bits_o (par_bits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      proj_q      <= '0;
      row_q       <= '0;
      step_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      proj_q      <= proj_d;
      row_q       <= row_d;
      step_q      <= step_d;
      rd_valid_q  <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= row_q;
    if (out_load) begin
      step_index_q <= step_q;
      row_index_q  <= 4'(proj_q);
      row_bits_q   <= 16'(par_bits);
      last_q       <= (proj_q == ColW'(BlockColumns - 1));
    end
  end

  always_comb begin
    state_d  = state_q;
    proj_d   = proj_q;
    row_d    = row_q;
    step_d   = step_q;
    rd_en    = 1'b0;
    out_load = 1'b0;
    flip     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op == OP_STEP)) begin
          state_d = ST_PROJ;
          proj_d  = '0;
        end
      end
      ST_PROJ: begin
        if (out_free) begin
          out_load = 1'b1;
          if (proj_q == ColW'(BlockColumns - 1)) begin
            state_d = ST_MUL;
            row_d   = '0;
          end else begin
            proj_d = proj_q + 1'b1;
          end
        end
      end
      ST_MUL: begin
        rd_en = 1'b1;
        if (row_q == RowW'(MatrixDim - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last product row is written back on this edge as the halves swap.
        flip    = 1'b1;
        step_d  = step_q + 1'b1;
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d  = out_load || (out_valid_q && out_stall_i);

  assign out_valid_o  = out_valid_q;
  assign step_index_o = step_index_q;
  assign row_index_o  = row_index_q;
  assign row_bits_o   = row_bits_q;
  assign last_o       = last_q;

`ifndef ASSERT_OFF
  a_new_beat_from_proj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_PROJ)
    else $error("result beat appeared outside the projection phase");

  a_last_before_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROJ) ##1 (state_q == ST_MUL) |-> out_valid_o && last_o)
    else $error("matrix phase began without the final row in the output");

  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> step_q == StepW'($past(step_q) + 1'b1))
    else $error("step counter did not advance at the end of a step");

  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROJ || state_q == ST_MUL) |=> $stable(step_q))
    else $error("step counter changed in the middle of a step");
`endif

endmodule
